[sv/jep_pkg.sv]
// Shared types and constants for the jitter entropy pool.
// Used by jep_front, jep_back and the top level; depends on nothing else.
package jep_pkg;

    localparam int POOL_DEPTH_DEF       = 8;
    localparam int SAMPLES_PER_WORD_DEF = 32;

    localparam int WORD_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int AVAIL_W = 4;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Shift amounts of the one-at-a-time hash.
    localparam int MIX_SHL  = 10;
    localparam int MIX_SHR  = 6;
    localparam int FIN_SHL1 = 3;
    localparam int FIN_SHR  = 11;
    localparam int FIN_SHL2 = 15;

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } op_e_t;

    typedef struct packed
    {
        op_e_t              op;
        logic [BYTE_W-1:0]  sample;
    } cmd_t;

    typedef enum logic [2:0]
    {
        BK_IDLE,
        BK_READ,
        BK_MIX,
        BK_FIN1,
        BK_FIN2
    } back_state_t;

endpackage

[sv/jep_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the sample store and the pool words.
module jep_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/jep_front.sv]
// Front end: takes command beats, classifies them and queues them for the back end.
// Depends on jep_pkg.
module jep_front (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       opcode,
    input  logic [jep_pkg::BYTE_W-1:0] sample_byte,
    output logic                       q_valid,
    output jep_pkg::cmd_t              q_cmd,
    input  logic                       q_pop
);

    localparam int PTR_W = $clog2(jep_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(jep_pkg::QUEUE_DEPTH + 1);

    jep_pkg::cmd_t    q_mem_reg [jep_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    jep_pkg::cmd_t    in_cmd;
    logic             push;
    logic             pop;

    // A read request carries no sample; its byte field is cleared.
    always_comb
    begin
        in_cmd.op     = opcode ? jep_pkg::OP_READ : jep_pkg::OP_SAMPLE;
        in_cmd.sample = opcode ? '0 : sample_byte;
    end

    assign busy    = (cnt_reg == CNT_W'(jep_pkg::QUEUE_DEPTH));
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_cmd   = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(jep_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(jep_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

[sv/jep_back.sv]
// Back end: executes queued commands, hashes full sample blocks into the pool
// and drives the result beat. Depends on jep_pkg and jep_ram.
module jep_back #(
    parameter int POOL_DEPTH       = jep_pkg::POOL_DEPTH_DEF,
    parameter int SAMPLES_PER_WORD = jep_pkg::SAMPLES_PER_WORD_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  jep_pkg::cmd_t               q_cmd,
    output logic                        q_pop,
    output logic                        done,
    output logic [jep_pkg::WORD_W-1:0]  random_word,
    output logic                        word_valid,
    output logic [jep_pkg::AVAIL_W-1:0] words_available
);

    localparam int PIDX_W = $clog2(POOL_DEPTH);
    localparam int FILL_W = $clog2(POOL_DEPTH + 1);
    localparam int SIDX_W = $clog2(SAMPLES_PER_WORD);
    localparam int WW     = jep_pkg::WORD_W;
    localparam int BW     = jep_pkg::BYTE_W;
    localparam int AW     = jep_pkg::AVAIL_W;

    jep_pkg::back_state_t state_reg, state_next;
    logic [SIDX_W-1:0]     count_reg, count_next;
    logic [SIDX_W-1:0]     k_reg, k_next;
    logic [PIDX_W-1:0]     head_reg, head_next;
    logic [PIDX_W-1:0]     slot_reg, slot_next;
    logic [FILL_W-1:0]     fill_reg, fill_next;
    logic [WW-1:0]         hash_reg, hash_next;
    logic [POOL_DEPTH-1:0] pvalid_reg, pvalid_next;
    logic                  done_reg, done_next;
    logic [WW-1:0]         word_reg, word_next;
    logic                  wvalid_reg, wvalid_next;
    logic [AW-1:0]         avail_reg, avail_next;

    logic [FILL_W:0]       slot_sum;
    logic [FILL_W:0]       slot_wrap;
    logic [PIDX_W-1:0]     slot_calc;
    logic [PIDX_W-1:0]     head_inc;
    logic                  pool_full;
    logic [FILL_W-1:0]     fill_after;

    logic                  samp_we;
    logic [SIDX_W-1:0]     samp_raddr;
    logic [BW-1:0]         samp_rdata;
    logic                  pool_we;
    logic [PIDX_W-1:0]     pool_raddr;
    logic [WW-1:0]         pool_rdata;

    logic [WW-1:0]         h_in;
    logic [WW-1:0]         mix_a, mix_b, mix_c;
    logic [WW-1:0]         fin_b, fin_c, fin_d;

    jep_ram #(.WIDTH(BW), .DEPTH(SAMPLES_PER_WORD)) u_samples (
        .clk   (clk),
        .we    (samp_we),
        .waddr (count_reg),
        .wdata (q_cmd.sample),
        .raddr (samp_raddr),
        .rdata (samp_rdata)
    );

    jep_ram #(.WIDTH(WW), .DEPTH(POOL_DEPTH)) u_pool (
        .clk   (clk),
        .we    (pool_we),
        .waddr (slot_reg),
        .wdata (fin_d),
        .raddr (pool_raddr),
        .rdata (pool_rdata)
    );

    // Next free slot: head plus fill stays below twice the depth.
    assign slot_sum  = (FILL_W+1)'(head_reg) + (FILL_W+1)'(fill_reg);
    assign slot_wrap = (slot_sum >= (FILL_W+1)'(POOL_DEPTH)) ?
                       slot_sum - (FILL_W+1)'(POOL_DEPTH) : slot_sum;
    assign slot_calc = slot_wrap[PIDX_W-1:0];
    assign head_inc  = (head_reg == PIDX_W'(POOL_DEPTH - 1)) ? '0 : head_reg + PIDX_W'(1);
    assign pool_full = (fill_reg == FILL_W'(POOL_DEPTH));
    assign fill_after = pool_full ? fill_reg : fill_reg + FILL_W'(1);

    // A slot never written is read as zero, through its cleared valid bit.
    assign h_in  = (k_reg == '0) ? (pvalid_reg[slot_reg] ? pool_rdata : '0) : hash_reg;
    assign mix_a = h_in + {{(WW-BW){1'b0}}, samp_rdata};
    assign mix_b = mix_a + (mix_a << jep_pkg::MIX_SHL);
    assign mix_c = mix_b ^ (mix_b >> jep_pkg::MIX_SHR);
    assign fin_b = hash_reg + (hash_reg << jep_pkg::FIN_SHL1);
    assign fin_c = fin_b ^ (fin_b >> jep_pkg::FIN_SHR);
    assign fin_d = hash_reg + (hash_reg << jep_pkg::FIN_SHL2);

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        head_next   = head_reg;
        slot_next   = slot_reg;
        fill_next   = fill_reg;
        hash_next   = hash_reg;
        pvalid_next = pvalid_reg;
        done_next   = 1'b0;
        word_next   = '0;
        wvalid_next = 1'b0;
        avail_next  = avail_reg;
        q_pop       = 1'b0;
        samp_we     = 1'b0;
        samp_raddr  = '0;
        pool_we     = 1'b0;
        pool_raddr  = head_reg;

        unique case (state_reg)
            jep_pkg::BK_IDLE:
            begin
                // The pool read is issued here for a pop or for the mix seed.
                pool_raddr = (q_cmd.op == jep_pkg::OP_READ) ? head_reg : slot_calc;
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_cmd.op == jep_pkg::OP_READ)
                    begin
                        if (fill_reg != '0)
                        begin
                            state_next = jep_pkg::BK_READ;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            avail_next = AW'(fill_reg);
                        end
                    end
                    else
                    begin
                        samp_we = 1'b1;
                        if (count_reg == SIDX_W'(SAMPLES_PER_WORD - 1))
                        begin
                            count_next = '0;
                            slot_next  = slot_calc;
                            k_next     = '0;
                            state_next = jep_pkg::BK_MIX;
                        end
                        else
                        begin
                            count_next = count_reg + SIDX_W'(1);
                            done_next  = 1'b1;
                            avail_next = AW'(fill_reg);
                        end
                    end
                end
            end

            jep_pkg::BK_READ:
            begin
                done_next   = 1'b1;
                word_next   = pool_rdata;
                wvalid_next = 1'b1;
                head_next   = head_inc;
                fill_next   = fill_reg - FILL_W'(1);
                avail_next  = AW'(fill_reg - FILL_W'(1));
                state_next  = jep_pkg::BK_IDLE;
            end

            jep_pkg::BK_MIX:
            begin
                // Prefetch the next byte; the wrap on the last step is unused.
                samp_raddr = k_reg + SIDX_W'(1);
                hash_next  = mix_c;
                k_next     = k_reg + SIDX_W'(1);
                if (k_reg == SIDX_W'(SAMPLES_PER_WORD - 1))
                begin
                    state_next = jep_pkg::BK_FIN1;
                end
            end

            jep_pkg::BK_FIN1:
            begin
                hash_next  = fin_c;
                state_next = jep_pkg::BK_FIN2;
            end

            jep_pkg::BK_FIN2:
            begin
                pool_we               = 1'b1;
                pvalid_next[slot_reg] = 1'b1;
                fill_next             = fill_after;
                if (pool_full)
                begin
                    head_next = head_inc;
                end
                done_next  = 1'b1;
                avail_next = AW'(fill_after);
                state_next = jep_pkg::BK_IDLE;
            end

            default:
            begin
                state_next = jep_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= jep_pkg::BK_IDLE;
            count_reg  <= '0;
            head_reg   <= '0;
            fill_reg   <= '0;
            pvalid_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            pvalid_reg <= pvalid_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        slot_reg   <= slot_next;
        hash_reg   <= hash_next;
        word_reg   <= word_next;
        wvalid_reg <= wvalid_next;
        avail_reg  <= avail_next;
    end

    assign done            = done_reg;
    assign random_word     = word_reg;
    assign word_valid      = wvalid_reg;
    assign words_available = avail_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(POOL_DEPTH))
        else $error("pool fill count exceeds pool depth");

    a_done_source: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == jep_pkg::BK_IDLE ||
                      $past(state_reg) == jep_pkg::BK_READ ||
                      $past(state_reg) == jep_pkg::BK_FIN2))
        else $error("result beat raised from a hashing state");

    a_valid_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && wvalid_reg) |-> ($past(state_reg) == jep_pkg::BK_READ))
        else $error("valid word reported without a pool pop");

    a_pop_written: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jep_pkg::BK_READ) |-> pvalid_reg[head_reg])
        else $error("pop from a pool slot that was never written");

    a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == jep_pkg::BK_FIN2) |=> (done_reg && state_reg == jep_pkg::BK_IDLE))
        else $error("finished hash did not produce a result beat");

endmodule

[sv/jitter_entropy_pool.sv]
// Jitter entropy pool: a sample byte or read request goes in per command beat,
// and one result beat comes out per command.
// Top level; depends on jep_pkg, jep_front, jep_back and jep_ram.
//
// Usage:
//   A command beat is taken at a rising edge with start high and busy low.
//   opcode 0 delivers a jitter sample byte, opcode 1 asks for one pool word.
//   Every command yields exactly one result beat, with done high for one
//   cycle; the receiver must take it then, as there is no way to hold it.
//   A two-entry command queue sits between the front and the back, so busy
//   only rises when two commands are already waiting.
// From acceptance to done, a command passes the queue and then the back end:
//   a sample that does not complete a block or an empty read is answered from idle,
//   a read that pops a word passes the pool read state,
//   the sample that completes a block runs one hash step per cycle over the
//   stored bytes in the back end, then two finishing steps. Commands are
//   executed one at a time.
// Reset clears the sample count, the pool head and fill and the pool-slot
// valid bits, so every pool word reads as zero until it is first mixed.
module jitter_entropy_pool #(
    parameter int POOL_DEPTH       = jep_pkg::POOL_DEPTH_DEF,
    parameter int SAMPLES_PER_WORD = jep_pkg::SAMPLES_PER_WORD_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        opcode,
    input  logic [jep_pkg::BYTE_W-1:0]  sample_byte,
    output logic                        done,
    output logic [jep_pkg::WORD_W-1:0]  random_word,
    output logic                        word_valid,
    output logic [jep_pkg::AVAIL_W-1:0] words_available
);

    logic          q_valid;
    logic          q_pop;
    jep_pkg::cmd_t q_cmd;

    jep_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .sample_byte (sample_byte),
        .q_valid     (q_valid),
        .q_cmd       (q_cmd),
        .q_pop       (q_pop)
    );

    jep_back #(
        .POOL_DEPTH       (POOL_DEPTH),
        .SAMPLES_PER_WORD (SAMPLES_PER_WORD)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .q_pop           (q_pop),
        .done            (done),
        .random_word     (random_word),
        .word_valid      (word_valid),
        .words_available (words_available)
    );

endmodule
